@@ src/bcc_pkg.sv @@
// Shared types, constants and helper functions for the button click classifier.
// No dependencies; every other file of the block but bcc_if imports this package.
package bcc_pkg;

    localparam int NUM_BUTTONS = 3;
    localparam int TIMER_BITS  = 16;
    localparam int CFG_W       = 16;
    localparam int CMP_W       = (TIMER_BITS > CFG_W) ? TIMER_BITS : CFG_W;
    localparam int COUNT_W     = 3;
    localparam int ADDR_W      = 4;
    localparam int DATA_W      = 32;

    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

    localparam logic [CFG_W-1:0] CLICK_MIN_RESET = 16'd100;
    localparam logic [CFG_W-1:0] HOLD_RESET      = 16'd500;
    localparam logic [CFG_W-1:0] GAP_RESET       = 16'd400;

    typedef enum logic [1:0] {
        REG_CLICK_MIN = 2'd0,
        REG_HOLD      = 2'd1,
        REG_GAP       = 2'd2
    } reg_index_t;

    typedef enum logic [1:0] {
        PH_IDLE    = 2'd0,
        PH_PRESSED = 2'd1,
        PH_GAP     = 2'd2
    } phase_t;

    typedef enum logic [2:0] {
        EV_NONE     = 3'd0,
        EV_SINGLE   = 3'd1,
        EV_DOUBLE   = 3'd2,
        EV_FIVE     = 3'd3,
        EV_HOLD     = 3'd4,
        EV_RELEASED = 3'd5
    } btn_event_t;

    typedef struct packed {
        logic [CFG_W-1:0] click_min_ms;
        logic [CFG_W-1:0] hold_ms;
        logic [CFG_W-1:0] gap_ms;
    } cfg_t;

    function automatic logic [TIMER_BITS-1:0] sat_inc(input logic [TIMER_BITS-1:0] t);
        logic [TIMER_BITS-1:0] r;
        r = (&t) ? t : t + 1'b1;
        return r;
    endfunction

    function automatic btn_event_t classify(input logic [COUNT_W-1:0] count);
        btn_event_t r;
        case (count)
            3'd1:    r = EV_SINGLE;
            3'd2:    r = EV_DOUBLE;
            3'd5:    r = EV_FIVE;
            default: r = EV_NONE;
        endcase
        return r;
    endfunction

endpackage

@@ src/bcc_if.sv @@
// Handshake channels of the button click classifier: tick input and event output.
// Depends on nothing but the fixed field widths of the block.
interface bcc_in_if;
    logic valid;
    logic ready;
    logic button0_pressed;
    logic button1_pressed;
    logic button2_pressed;

    modport source (output valid, output button0_pressed, output button1_pressed,
                    output button2_pressed, input ready);
    modport sink   (input valid, input button0_pressed, input button1_pressed,
                    input button2_pressed, output ready);
endinterface

interface bcc_out_if;
    logic       valid;
    logic       ready;
    logic [2:0] button0_event;
    logic [2:0] button1_event;
    logic [2:0] button2_event;

    modport source (output valid, output button0_event, output button1_event,
                    output button2_event, input ready);
    modport sink   (input valid, input button0_event, input button1_event,
                    input button2_event, output ready);
endinterface

@@ src/button_click_classifier.sv @@
// Button click classifier top level: lanes, merging stage and APB registers.
// Depends on bcc_pkg, bcc_if, bcc_regs, bcc_lane and bcc_merge.
//
//   channel   direction   carries
//   in_ch     sink        one tick: buttonN_pressed
//   out_ch    source      one result: buttonN_event
//   APB       slave       click_min_ms, hold_ms, gap_ms at 0x0, 0x4, 0x8
//
// One item is accepted per cycle unless out_ch stalls; result next cycle.
// Each lane updates its timers and click count in the accepting cycle.
// The output register lets a new item in while the held result is taken.
// Reset loads the register defaults and returns all lanes to idle.
module button_click_classifier (
    input  logic                          clk,
    input  logic                          rst_n,
    bcc_in_if.sink                        in_ch,
    bcc_out_if.source                     out_ch,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [bcc_pkg::ADDR_W-1:0]    paddr,
    input  logic [bcc_pkg::DATA_W-1:0]    pwdata,
    output logic [bcc_pkg::DATA_W-1:0]    prdata,
    output logic                          pready
);
    import bcc_pkg::*;

    cfg_t                   cfg;
    logic [NUM_BUTTONS-1:0] level;
    btn_event_t             lane_ev [NUM_BUTTONS];
    logic                   ready;
    logic                   accept;

    assign level       = {in_ch.button2_pressed, in_ch.button1_pressed,
                          in_ch.button0_pressed};
    assign in_ch.ready = ready;
    assign accept      = in_ch.valid && ready;

    bcc_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    for (genvar i = 0; i < NUM_BUTTONS; i++)
    begin : g_lane
        bcc_lane u_lane (
            .clk    (clk),
            .rst_n  (rst_n),
            .accept (accept),
            .level  (level[i]),
            .cfg    (cfg),
            .ev     (lane_ev[i])
        );
    end

    bcc_merge u_merge (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_ch.valid),
        .in_ready (ready),
        .lane_ev  (lane_ev),
        .out_ch   (out_ch)
    );

endmodule

@@ src/bcc_regs.sv @@
// APB configuration registers: click minimum, hold time and gap time.
// Depends on bcc_pkg.
module bcc_regs (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [bcc_pkg::ADDR_W-1:0]    paddr,
    input  logic [bcc_pkg::DATA_W-1:0]    pwdata,
    output logic [bcc_pkg::DATA_W-1:0]    prdata,
    output logic                          pready,
    output bcc_pkg::cfg_t                 cfg
);
    import bcc_pkg::*;

    cfg_t       cfg_reg;
    cfg_t       cfg_next;
    reg_index_t index;
    logic       wr_en;

    assign pready = 1'b1;
    assign index  = reg_index_t'(paddr[3:2]);
    assign wr_en  = psel && penable && pwrite;
    assign cfg    = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            case (index)
                REG_CLICK_MIN: cfg_next.click_min_ms = pwdata[CFG_W-1:0];
                REG_HOLD:      cfg_next.hold_ms      = pwdata[CFG_W-1:0];
                REG_GAP:       cfg_next.gap_ms       = pwdata[CFG_W-1:0];
                default:       cfg_next              = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        case (index)
            REG_CLICK_MIN: prdata = DATA_W'(cfg_reg.click_min_ms);
            REG_HOLD:      prdata = DATA_W'(cfg_reg.hold_ms);
            REG_GAP:       prdata = DATA_W'(cfg_reg.gap_ms);
            default:       prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.click_min_ms <= CLICK_MIN_RESET;
            cfg_reg.hold_ms      <= HOLD_RESET;
            cfg_reg.gap_ms       <= GAP_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

@@ src/bcc_lane.sv @@
// One button lane: press and gap timers, click count and hold flag.
// Depends on bcc_pkg; computes the event of the current tick from its state.
module bcc_lane (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 accept,
    input  logic                 level,
    input  bcc_pkg::cfg_t        cfg,
    output bcc_pkg::btn_event_t  ev
);
    import bcc_pkg::*;

    phase_t               phase_reg;
    phase_t               phase_next;
    logic [TIMER_BITS-1:0] press_reg;
    logic [TIMER_BITS-1:0] press_next;
    logic [TIMER_BITS-1:0] gap_reg;
    logic [TIMER_BITS-1:0] gap_next;
    logic [COUNT_W-1:0]    count_reg;
    logic [COUNT_W-1:0]    count_next;
    logic                  hold_reg;
    logic                  hold_next;
    logic [TIMER_BITS-1:0] press_inc;
    logic [TIMER_BITS-1:0] gap_inc;

    assign press_inc = sat_inc(press_reg);
    assign gap_inc   = sat_inc(gap_reg);

    always_comb
    begin
        phase_next = phase_reg;
        press_next = press_reg;
        gap_next   = gap_reg;
        count_next = count_reg;
        hold_next  = hold_reg;
        ev         = EV_NONE;
        if (level)
        begin
            if (phase_reg != PH_PRESSED)
            begin
                phase_next = PH_PRESSED;
                press_next = '0;
                hold_next  = 1'b0;
            end
            else
            begin
                press_next = press_inc;
            end
            if (!hold_next && CMP_W'(press_next) >= CMP_W'(cfg.hold_ms))
            begin
                hold_next = 1'b1;
                ev        = EV_HOLD;
            end
        end
        else
        begin
            case (phase_reg)
                PH_PRESSED:
                begin
                    if (hold_reg)
                    begin
                        phase_next = PH_IDLE;
                        press_next = '0;
                        gap_next   = '0;
                        count_next = '0;
                        hold_next  = 1'b0;
                        ev         = EV_RELEASED;
                    end
                    else
                    begin
                        press_next = press_inc;
                        if (CMP_W'(press_inc) >= CMP_W'(cfg.click_min_ms)
                            && CMP_W'(press_inc) < CMP_W'(cfg.hold_ms)
                            && count_reg != COUNT_MAX)
                        begin
                            count_next = count_reg + 1'b1;
                        end
                        phase_next = PH_GAP;
                        gap_next   = '0;
                        if (cfg.gap_ms == '0)
                        begin
                            ev         = classify(count_next);
                            phase_next = PH_IDLE;
                            press_next = '0;
                            count_next = '0;
                        end
                    end
                end
                PH_GAP:
                begin
                    gap_next = gap_inc;
                    if (CMP_W'(gap_inc) >= CMP_W'(cfg.gap_ms))
                    begin
                        ev         = classify(count_reg);
                        phase_next = PH_IDLE;
                        press_next = '0;
                        gap_next   = '0;
                        count_next = '0;
                        hold_next  = 1'b0;
                    end
                end
                default:
                begin
                    phase_next = PH_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE;
            press_reg <= '0;
            gap_reg   <= '0;
            count_reg <= '0;
            hold_reg  <= 1'b0;
        end
        else if (accept)
        begin
            phase_reg <= phase_next;
            press_reg <= press_next;
            gap_reg   <= gap_next;
            count_reg <= count_next;
            hold_reg  <= hold_next;
        end
    end

endmodule

@@ src/bcc_merge.sv @@
// Merging stage: gathers the lane events of one tick into the output register.
// Depends on bcc_pkg and bcc_out_if.
module bcc_merge (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  bcc_pkg::btn_event_t  lane_ev [bcc_pkg::NUM_BUTTONS],
    bcc_out_if.source            out_ch
);
    import bcc_pkg::*;

    logic       valid_reg;
    logic       valid_next;
    btn_event_t ev_reg [NUM_BUTTONS];
    logic       load;

    assign in_ready = !valid_reg || out_ch.ready;
    assign load     = in_valid && in_ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (out_ch.ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            ev_reg <= lane_ev;
        end
    end

    assign out_ch.valid         = valid_reg;
    assign out_ch.button0_event = ev_reg[0];
    assign out_ch.button1_event = ev_reg[1];
    assign out_ch.button2_event = ev_reg[2];

endmodule
